// ----- design/unicode_transcoder_top_assert.svh -----
// Assertion helpers shared by the transcoder modules.
// Both expect clk and rst_n in scope.
`ifndef UNICODE_TRANSCODER_TOP_ASSERT_SVH
`define UNICODE_TRANSCODER_TOP_ASSERT_SVH

// same-cycle implication
`define UTC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/utc_pkg.sv -----
package utc_pkg;

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_FORMAT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_FORMAT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_CAP    = 2'd2;

  localparam logic [2:0] FMT_ASCII7  = 3'd0;
  localparam logic [2:0] FMT_UTF8    = 3'd1;
  localparam logic [2:0] FMT_UTF16LE = 3'd2;
  localparam logic [2:0] FMT_UTF16BE = 3'd3;
  localparam logic [2:0] FMT_UTF32LE = 3'd4;
  localparam logic [2:0] FMT_UTF32BE = 3'd5;

  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  localparam logic [7:0]  QMARK      = 8'h3F;
  localparam logic [7:0]  LEAD4_MIN  = 8'hF0;
  localparam logic [7:0]  LEAD3_MIN  = 8'hE0;
  localparam logic [7:0]  LEAD2_MIN  = 8'hC0;
  localparam logic [7:0]  CONT_MARK  = 8'h80;
  localparam logic [15:0] SURR_FIRST = 16'hD800;
  localparam logic [15:0] SURR_HI_LAST = 16'hDBFF;
  localparam logic [15:0] SURR_LO_FIRST = 16'hDC00;
  localparam logic [15:0] SURR_LAST  = 16'hDFFF;

  // one encoded character waiting for the output side
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [1:0]      last_idx;
  } utc_entry_t;

endpackage

// ----- design/utc_front.sv -----
module utc_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [utc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                        cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_command,
  input  logic [7:0]                         in_data_byte,
  input  logic                               in_final_byte,
  input  logic                               q_full,
  output logic                               push,
  output utc_pkg::utc_entry_t                push_entry
);

  logic [2:0]      src_fmt_r, src_fmt_nxt;
  logic [2:0]      dst_fmt_r, dst_fmt_nxt;
  logic [31:0]     cap_r, cap_nxt;
  logic [31:0]     room_r, room_nxt;
  logic [2:0]      count_r, count_nxt;
  logic            halted_r, halted_nxt;
  logic [3:0][7:0] gbytes_r, gbytes_nxt;

  logic            fire;
  logic [3:0][7:0] gview;
  logic [2:0]      cnt1;
  logic [2:0]      need;
  logic [15:0]     u0, u1;
  logic            sur0;
  logic [31:0]     cp;
  logic [3:0][7:0] enc;
  logic [2:0]      enc_n;
  logic            enc_bad;
  logic            fmt_bad;
  logic            over16, big16;
  logic [3:0]      t_hi;
  logic [15:0]     hi16, lo16;

  assign in_stall = q_full;
  assign fire     = in_valid && !q_full;
  assign fmt_bad  = (src_fmt_r > utc_pkg::FMT_UTF32BE) || (dst_fmt_r > utc_pkg::FMT_UTF32BE);

  // gathered bytes with the incoming byte dropped into its slot
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      gview[i] = (count_r[1:0] == 2'(i)) ? in_data_byte : gbytes_r[i];
    end
    cnt1 = count_r + 3'd1;
    u0   = (src_fmt_r == utc_pkg::FMT_UTF16LE) ? {gview[1], gview[0]} : {gview[0], gview[1]};
    u1   = (src_fmt_r == utc_pkg::FMT_UTF16LE) ? {gview[3], gview[2]} : {gview[2], gview[3]};
    sur0 = u0 inside {[utc_pkg::SURR_FIRST : utc_pkg::SURR_LAST]};
  end

  always_comb begin
    case (src_fmt_r)
      utc_pkg::FMT_ASCII7: need = 3'd1;
      utc_pkg::FMT_UTF8: begin
        if (gview[0] >= utc_pkg::LEAD4_MIN)      need = 3'd4;
        else if (gview[0] >= utc_pkg::LEAD3_MIN) need = 3'd3;
        else if (gview[0] >= utc_pkg::LEAD2_MIN) need = 3'd2;
        else                                     need = 3'd1;
      end
      utc_pkg::FMT_UTF16LE, utc_pkg::FMT_UTF16BE: begin
        if (cnt1 < 3'd2) need = 3'd2;
        else             need = sur0 ? 3'd4 : 3'd2;
      end
      default: need = 3'd4;
    endcase
  end

  // decode
  always_comb begin
    case (src_fmt_r)
      utc_pkg::FMT_ASCII7: cp = gview[0][7] ? {24'd0, utc_pkg::QMARK} : {24'd0, gview[0]};
      utc_pkg::FMT_UTF8: begin
        if (gview[0] >= utc_pkg::LEAD4_MIN)
          cp = {11'd0, gview[0][2:0], gview[1][5:0], gview[2][5:0], gview[3][5:0]};
        else if (gview[0] >= utc_pkg::LEAD3_MIN)
          cp = {16'd0, gview[0][3:0], gview[1][5:0], gview[2][5:0]};
        else if (gview[0] >= utc_pkg::LEAD2_MIN)
          cp = {21'd0, gview[0][4:0], gview[1][5:0]};
        else
          cp = gview[0][7] ? {24'd0, utc_pkg::QMARK} : {24'd0, gview[0]};
      end
      utc_pkg::FMT_UTF16LE, utc_pkg::FMT_UTF16BE: begin
        if (!sur0)
          cp = {16'd0, u0};
        else if (u0 > utc_pkg::SURR_HI_LAST ||
                 !(u1 inside {[utc_pkg::SURR_LO_FIRST : utc_pkg::SURR_LAST]}))
          cp = {24'd0, utc_pkg::QMARK};
        else
          // +0x10000 only touches the plane bits
          cp = {11'd0, 5'({1'b0, u0[9:6]} + 5'd1), u0[5:0], u1[9:0]};
      end
      utc_pkg::FMT_UTF32LE: cp = {gview[3], gview[2], gview[1], gview[0]};
      default:              cp = {gview[0], gview[1], gview[2], gview[3]};
    endcase
  end

  // encode
  always_comb begin
    over16 = (|cp[31:21]) || (cp[20] && (|cp[19:16]));
    big16  = |cp[20:16];
    t_hi   = 4'(cp[20:16] - 5'd1);
    hi16   = big16 ? (utc_pkg::SURR_FIRST | {6'd0, t_hi, cp[15:10]}) : cp[15:0];
    lo16   = big16 ? (utc_pkg::SURR_LO_FIRST | {6'd0, cp[9:0]}) : 16'd0;
    enc     = '0;
    enc_n   = 3'd1;
    enc_bad = 1'b0;
    case (dst_fmt_r)
      utc_pkg::FMT_ASCII7: enc[0] = (|cp[31:7]) ? utc_pkg::QMARK : cp[7:0];
      utc_pkg::FMT_UTF8: begin
        if (|cp[31:16]) begin
          enc[0] = utc_pkg::LEAD4_MIN | {5'd0, cp[20:18]};
          enc[1] = utc_pkg::CONT_MARK | {2'd0, cp[17:12]};
          enc[2] = utc_pkg::CONT_MARK | {2'd0, cp[11:6]};
          enc[3] = utc_pkg::CONT_MARK | {2'd0, cp[5:0]};
          enc_n  = 3'd4;
        end else if (|cp[15:11]) begin
          enc[0] = utc_pkg::LEAD3_MIN | {4'd0, cp[15:12]};
          enc[1] = utc_pkg::CONT_MARK | {2'd0, cp[11:6]};
          enc[2] = utc_pkg::CONT_MARK | {2'd0, cp[5:0]};
          enc_n  = 3'd3;
        end else if (|cp[10:7]) begin
          enc[0] = utc_pkg::LEAD2_MIN | {3'd0, cp[10:6]};
          enc[1] = utc_pkg::CONT_MARK | {2'd0, cp[5:0]};
          enc_n  = 3'd2;
        end else begin
          enc[0] = cp[7:0];
        end
      end
      utc_pkg::FMT_UTF16LE: begin
        enc     = {lo16[15:8], lo16[7:0], hi16[15:8], hi16[7:0]};
        enc_n   = big16 ? 3'd4 : 3'd2;
        enc_bad = over16;
      end
      utc_pkg::FMT_UTF16BE: begin
        enc     = {lo16[7:0], lo16[15:8], hi16[7:0], hi16[15:8]};
        enc_n   = big16 ? 3'd4 : 3'd2;
        enc_bad = over16;
      end
      utc_pkg::FMT_UTF32LE: begin
        enc   = {cp[31:24], cp[23:16], cp[15:8], cp[7:0]};
        enc_n = 3'd4;
      end
      default: begin
        enc   = {cp[7:0], cp[15:8], cp[23:16], cp[31:24]};
        enc_n = 3'd4;
      end
    endcase
  end

  always_comb begin
    src_fmt_nxt = src_fmt_r;
    dst_fmt_nxt = dst_fmt_r;
    cap_nxt     = cap_r;
    room_nxt    = room_r;
    count_nxt   = count_r;
    halted_nxt  = halted_r;
    gbytes_nxt  = gbytes_r;
    push        = 1'b0;
    if (fire) begin
      if (in_command == utc_pkg::CMD_RESTART) begin
        count_nxt  = 3'd0;
        halted_nxt = 1'b0;
        room_nxt   = cap_r;
      end else if (!fmt_bad && !halted_r) begin
        gbytes_nxt[count_r[1:0]] = in_data_byte;
        if (cnt1 >= need) begin
          count_nxt = 3'd0;
          if (enc_bad || room_r < 32'(enc_n)) begin
            halted_nxt = 1'b1;
          end else begin
            room_nxt = room_r - 32'(enc_n);
            push     = 1'b1;
          end
        end else begin
          count_nxt = cnt1;
        end
        if (in_final_byte) count_nxt = 3'd0;
      end
    end
    if (cfg_wr_en) begin
      case (cfg_index)
        utc_pkg::CFG_SRC_FORMAT: begin
          src_fmt_nxt = cfg_wr_data[2:0];
          count_nxt   = 3'd0;
        end
        utc_pkg::CFG_DEST_FORMAT: dst_fmt_nxt = cfg_wr_data[2:0];
        utc_pkg::CFG_DEST_CAP: begin
          cap_nxt  = cfg_wr_data;
          room_nxt = cfg_wr_data;
        end
        default: ;
      endcase
    end
  end

  assign push_entry.data     = enc;
  assign push_entry.last_idx = 2'(enc_n - 3'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_fmt_r <= utc_pkg::FMT_UTF8;
      dst_fmt_r <= utc_pkg::FMT_UTF8;
      cap_r     <= '1;
      room_r    <= '1;
      count_r   <= 3'd0;
      halted_r  <= 1'b0;
    end else begin
      src_fmt_r <= src_fmt_nxt;
      dst_fmt_r <= dst_fmt_nxt;
      cap_r     <= cap_nxt;
      room_r    <= room_nxt;
      count_r   <= count_nxt;
      halted_r  <= halted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gbytes_r <= gbytes_nxt;
  end

endmodule

// ----- design/utc_fifo.sv -----
module utc_fifo #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  utc_pkg::utc_entry_t push_entry,
  input  logic                pop,
  output logic                full,
  output logic                not_empty,
  output utc_pkg::utc_entry_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  utc_pkg::utc_entry_t mem_r [DEPTH];
  logic [PW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]       count_r, count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (!push && pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

`include "unicode_transcoder_top_assert.svh"

  `UTC_ASSERT_NOW(a_no_push_full, push, !full, "write into full character queue")
  `UTC_ASSERT_NOW(a_no_pop_empty, pop, not_empty, "read from empty character queue")

endmodule

// ----- design/utc_back.sv -----
module utc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                not_empty,
  input  utc_pkg::utc_entry_t head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                out_run_end
);

  logic [1:0] idx_r, idx_nxt;
  logic       accept;

  assign out_valid   = not_empty;
  assign out_byte    = head.data[idx_r];
  assign out_run_end = (idx_r == head.last_idx);
  assign accept      = out_valid && !out_stall;
  assign pop         = accept && out_run_end;

  always_comb begin
    idx_nxt = idx_r;
    if (accept) idx_nxt = out_run_end ? 2'd0 : idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= 2'd0;
    else        idx_r <= idx_nxt;
  end

`include "unicode_transcoder_top_assert.svh"

  `UTC_ASSERT_NOW(a_idx_in_char, not_empty, idx_r <= head.last_idx, "byte index past character end")
  `UTC_ASSERT_NEXT(a_char_continues, accept && !out_run_end, out_valid && idx_r != 2'd0, "character cut short")

endmodule

// ----- design/unicode_transcoder_top.sv -----
// Streaming transcoder between ASCII7, UTF-8, UTF-16LE/BE and UTF-32LE/BE. The front end takes
// one source byte per cycle whenever the character queue has room, gathers the bytes of a
// character, decodes and re-encodes it in that same cycle and queues the 1 to 4 output bytes;
// the output side sends one byte per cycle while out_stall is low, run_end marking a character's
// last byte. A character is registered in the queue before its first output byte appears.
// Sustained rate is set by the output serialiser, which sends a character's output bytes one at
// a time, up to 4 per input byte (e.g. ASCII7 to UTF-32). QUEUE_DEPTH characters can wait between the two sides.
module unicode_transcoder_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [utc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_command,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_final_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_byte,
  output logic                          out_run_end
);

  logic                q_full;
  logic                q_not_empty;
  logic                q_push;
  logic                q_pop;
  utc_pkg::utc_entry_t q_in;
  utc_pkg::utc_entry_t q_head;

  utc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_data_byte  (in_data_byte),
    .in_final_byte (in_final_byte),
    .q_full        (q_full),
    .push          (q_push),
    .push_entry    (q_in)
  );

  utc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  utc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .not_empty   (q_not_empty),
    .head        (q_head),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .out_run_end (out_run_end)
  );

endmodule
